// File: rtl/core/alf_pkg.sv
`default_nettype none
package alf_pkg;

	localparam int NumBlocks = 4096;
	localparam int WordBits = 64;
	localparam int NumWords = NumBlocks / WordBits;
	localparam int BitW = $clog2(WordBits);
	localparam int WordAddrW = $clog2(NumWords);
	localparam int BlockW = $clog2(NumBlocks);
	localparam int CountW = BlockW + 1;
	localparam int MaxRun = 64;
	localparam int RunW = $clog2(MaxRun + 1);

	typedef enum logic [2:0] {
		CMD_ALLOC_BYTES = 3'd0,
		CMD_ALLOC_ONE   = 3'd1,
		CMD_FREE_CHK    = 3'd2,
		CMD_FREE        = 3'd3,
		CMD_REINIT      = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ST_GIVEN    = 3'd0,
		ST_NOTHING  = 3'd1,
		ST_NOSPACE  = 3'd2,
		ST_TOOLARGE = 3'd3,
		ST_FREED    = 3'd4,
		ST_IGNORED  = 3'd5,
		ST_REINIT   = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		REG_BLOCK_SIZE_LOG2 = 2'd0,
		REG_TOTAL_BLOCKS    = 2'd1,
		REG_LOCAL_SERVER    = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_CHECK,
		S_LOAD,
		S_GIVE,
		S_FREE
	} state_t;

	typedef struct packed {
		logic                 rd_en;
		logic [WordAddrW-1:0] rd_addr;
		logic                 wr_en;
		logic [WordAddrW-1:0] wr_addr;
		logic [WordBits-1:0]  wr_data;
		logic                 clear;
	} map_req_t;

	typedef struct packed {
		logic            found;
		logic [BitW-1:0] idx;
	} find_t;

	// lowest set bit of the candidate vector
	function automatic find_t lowest_set(input logic [WordBits-1:0] v);
		find_t r;
		r.found = 1'b0;
		r.idx = '0;
		for (int i = WordBits - 1; i >= 0; i--) begin
			if (v[i]) begin
				r.found = 1'b1;
				r.idx = BitW'(i);
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/alf_bitmap.sv
`default_nettype none
module alf_bitmap
	import alf_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire map_req_t            req,
	output logic [WordBits-1:0]      rdata
);

	logic [WordBits-1:0] mem [NumWords];
	logic [NumWords-1:0] row_valid_q;
	logic [WordBits-1:0] rd_word_q;
	logic                rd_valid_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_word_q <= mem[req.rd_addr];
		end
	end

	// rows never written since reset or reinit read as all free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (req.clear) begin
				row_valid_q <= '0;
			end else if (req.wr_en) begin
				row_valid_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_valid_q <= row_valid_q[req.rd_addr];
			end
		end
	end

	assign rdata = rd_valid_q ? rd_word_q : '0;

endmodule
`default_nettype wire

// File: rtl/core/alf_sizer.sv
`default_nettype none
module alf_sizer
	import alf_pkg::*;
(
	input  wire logic        clk,
	input  wire logic [31:0] bytes,
	input  wire logic [4:0]  size_log2,
	output logic [32:0]      nblocks_s1
);

	logic [32:0] bsize_m1;
	logic [32:0] sum;

	assign bsize_m1 = (33'd1 << size_log2) - 33'd1;
	assign sum = {1'b0, bytes} + bsize_m1;

	always_ff @(posedge clk) begin
		nblocks_s1 <= sum >> size_log2;
	end

endmodule
`default_nettype wire

// File: rtl/core/lowest_free_block_allocator.sv
`default_nettype none
// lowest-first block allocator over a 4096-bit in-use map held in a 64x64 ram
// allocations emit one block per cycle while the current bitmap word still has
//   free blocks inside the pool, and load the next word when it runs out
// one command at a time: start is only taken while busy is low
// reset: all blocks free, no blocks in use, registers at 12 / 4096 / 0
// results cannot be stalled: each sits on the ports for a single cycle
module lowest_free_block_allocator
	import alf_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  cmd,
	input  wire logic [31:0] request_bytes,
	input  wire logic [11:0] block_number,
	input  wire logic [7:0]  owner_server,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [12:0] cfg_wdata,
	output logic             result_valid,
	output logic [2:0]       status,
	output logic [11:0]      block_number_out,
	output logic             last,
	output logic [12:0]      used_count
);

	// configuration registers
	logic [4:0]        size_log2_q;
	logic [CountW-1:0] total_blocks_q;
	logic [7:0]        local_server_q;

	// command held for the whole operation
	logic [2:0]        cmd_q;
	logic [31:0]       bytes_q;
	logic [BlockW-1:0] bnum_q;
	logic [7:0]        owner_q;

	state_t               state_q, state_d;
	logic [CountW-1:0]    used_q, used_d;
	logic [RunW-1:0]      remain_q, remain_d;
	logic [WordAddrW-1:0] wptr_q, wptr_d;
	logic [WordBits-1:0]  cur_q, cur_d;

	// emitted result, registered onto the ports
	logic                 emit;
	status_t              emit_status;
	logic [BlockW-1:0]    emit_blk;
	logic                 emit_last;

	map_req_t             mreq;
	logic [WordBits-1:0]  rdata;
	logic [32:0]          nblocks_s1;

	alf_bitmap u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rdata  (rdata)
	);

	alf_sizer u_sizer (
		.clk        (clk),
		.bytes      (bytes_q),
		.size_log2  (size_log2_q),
		.nblocks_s1 (nblocks_s1)
	);

	// pool limit and free blocks left in it
	logic [CountW-1:0] limit;
	logic [CountW-1:0] avail;
	assign limit = (total_blocks_q > CountW'(NumBlocks)) ? CountW'(NumBlocks) : total_blocks_q;
	assign avail = (limit > used_q) ? (limit - used_q) : '0;

	// bits of the current word that lie inside the pool
	logic [CountW-1:0]   word_base;
	logic [CountW-1:0]   lim_off;
	logic [WordBits-1:0] in_pool;
	find_t               pick;
	assign word_base = {1'b0, wptr_q, {BitW{1'b0}}};
	assign lim_off = limit - word_base;
	always_comb begin
		if (limit <= word_base) begin
			in_pool = '0;
		end else if (lim_off >= CountW'(WordBits)) begin
			in_pool = '1;
		end else begin
			in_pool = (WordBits'(1) << lim_off[BitW-1:0]) - WordBits'(1);
		end
	end
	assign pick = lowest_set(~cur_q & in_pool);

	// word of the block being freed, with its bit cleared
	logic                bit_used;
	logic [WordBits-1:0] freed_word;
	assign bit_used = rdata[bnum_q[BitW-1:0]];
	always_comb begin
		freed_word = rdata;
		freed_word[bnum_q[BitW-1:0]] = 1'b0;
	end

	assign busy = (state_q != S_IDLE);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_d = S_DISPATCH;
			end
			S_DISPATCH: begin
				case (cmd_q)
					CMD_ALLOC_BYTES: state_d = S_CHECK;
					CMD_ALLOC_ONE:   state_d = (avail == '0) ? S_IDLE : S_LOAD;
					CMD_FREE_CHK:    state_d = (owner_q != local_server_q) ? S_IDLE : S_FREE;
					CMD_FREE:        state_d = S_FREE;
					default:         state_d = S_IDLE;
				endcase
			end
			S_CHECK: begin
				if (nblocks_s1 == '0 || nblocks_s1 > 33'(MaxRun)
						|| nblocks_s1 > 33'(avail)) begin
					state_d = S_IDLE;
				end else begin
					state_d = S_LOAD;
				end
			end
			S_LOAD: state_d = S_GIVE;
			S_GIVE: begin
				if (pick.found) begin
					if (remain_q == RunW'(1)) state_d = S_IDLE;
				end else begin
					state_d = S_LOAD;
				end
			end
			S_FREE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs, memory requests and datapath updates
	always_comb begin
		emit = 1'b0;
		emit_status = ST_NOTHING;
		emit_blk = '0;
		emit_last = 1'b1;
		used_d = used_q;
		remain_d = remain_q;
		wptr_d = wptr_q;
		cur_d = cur_q;
		mreq = '0;
		case (state_q)
			S_DISPATCH: begin
				case (cmd_q)
					CMD_ALLOC_BYTES: ;
					CMD_ALLOC_ONE: begin
						if (avail == '0) begin
							emit = 1'b1;
							emit_status = ST_NOSPACE;
						end else begin
							remain_d = RunW'(1);
							wptr_d = '0;
							mreq.rd_en = 1'b1;
							mreq.rd_addr = '0;
						end
					end
					CMD_FREE_CHK, CMD_FREE: begin
						if (cmd_q == CMD_FREE_CHK && owner_q != local_server_q) begin
							emit = 1'b1;
							emit_status = ST_IGNORED;
						end else begin
							mreq.rd_en = 1'b1;
							mreq.rd_addr = bnum_q[BlockW-1:BitW];
						end
					end
					CMD_REINIT: begin
						mreq.clear = 1'b1;
						used_d = '0;
						emit = 1'b1;
						emit_status = ST_REINIT;
					end
					default: begin
						emit = 1'b1;
						emit_status = ST_NOTHING;
					end
				endcase
			end
			S_CHECK: begin
				if (nblocks_s1 == '0) begin
					emit = 1'b1;
					emit_status = ST_NOTHING;
				end else if (nblocks_s1 > 33'(MaxRun)) begin
					emit = 1'b1;
					emit_status = ST_TOOLARGE;
				end else if (nblocks_s1 > 33'(avail)) begin
					emit = 1'b1;
					emit_status = ST_NOSPACE;
				end else begin
					remain_d = nblocks_s1[RunW-1:0];
					wptr_d = '0;
					mreq.rd_en = 1'b1;
					mreq.rd_addr = '0;
				end
			end
			S_LOAD: begin
				cur_d = rdata;
			end
			S_GIVE: begin
				if (pick.found) begin
					cur_d = cur_q;
					cur_d[pick.idx] = 1'b1;
					mreq.wr_en = 1'b1;
					mreq.wr_addr = wptr_q;
					mreq.wr_data = cur_d;
					used_d = used_q + CountW'(1);
					remain_d = remain_q - RunW'(1);
					emit = 1'b1;
					emit_status = ST_GIVEN;
					emit_blk = {wptr_q, pick.idx};
					emit_last = (remain_q == RunW'(1));
				end else begin
					// word exhausted inside the pool, move to the next one
					wptr_d = wptr_q + WordAddrW'(1);
					mreq.rd_en = 1'b1;
					mreq.rd_addr = wptr_d;
				end
			end
			S_FREE: begin
				emit = 1'b1;
				if (bit_used) begin
					mreq.wr_en = 1'b1;
					mreq.wr_addr = bnum_q[BlockW-1:BitW];
					mreq.wr_data = freed_word;
					if (used_q != '0) used_d = used_q - CountW'(1);
					emit_status = ST_FREED;
				end else begin
					emit_status = ST_IGNORED;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q <= '0;
			size_log2_q <= 5'd12;
			total_blocks_q <= CountW'(4096);
			local_server_q <= '0;
			result_valid <= 1'b0;
			remain_q <= '0;
			wptr_q <= '0;
		end else begin
			state_q <= state_d;
			used_q <= used_d;
			remain_q <= remain_d;
			wptr_q <= wptr_d;
			result_valid <= emit;
			if (cfg_we) begin
				case (cfg_index)
					REG_BLOCK_SIZE_LOG2: size_log2_q <= cfg_wdata[4:0];
					REG_TOTAL_BLOCKS:    total_blocks_q <= cfg_wdata;
					REG_LOCAL_SERVER:    local_server_q <= cfg_wdata[7:0];
					default: ;
				endcase
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		cur_q <= cur_d;
		if (start && !busy) begin
			cmd_q <= cmd;
			bytes_q <= request_bytes;
			bnum_q <= block_number;
			owner_q <= owner_server;
		end
		status <= emit_status;
		block_number_out <= emit_blk;
		last <= emit_last;
		used_count <= used_d;
	end

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CountW'(NumBlocks))
		else $error("blocks in use above pool size");

	a_fail_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status != ST_GIVEN |-> last)
		else $error("non-allocation result not marked last");

	a_give_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_GIVE |-> remain_q != '0)
		else $error("allocation loop with nothing left to give");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted command did not raise busy");

endmodule
`default_nettype wire

// File: tb/lowest_free_block_allocator_tb.sv
`timescale 1ns / 100ps
module lowest_free_block_allocator_tb
	import alf_pkg::*;
();

	// result record as it leaves the allocator
	typedef struct packed {
		logic [2:0]  status;
		logic [11:0] blk;
		logic        last;
		logic [12:0] used;
	} alloc_result_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  cmd;
	logic [31:0] request_bytes;
	logic [11:0] block_number;
	logic [7:0]  owner_server;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [12:0] cfg_wdata;
	logic        result_valid;
	logic [2:0]  status;
	logic [11:0] block_number_out;
	logic        last;
	logic [12:0] used_count;

	lowest_free_block_allocator dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.request_bytes(request_bytes), .block_number(block_number),
		.owner_server(owner_server), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .result_valid(result_valid), .status(status),
		.block_number_out(block_number_out), .last(last), .used_count(used_count)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// shadow copy of the pool and registers
	bit          in_use_map [NumBlocks];
	logic [12:0] used_blocks;
	logic [4:0]  blk_size_log2;
	logic [12:0] pool_total;
	logic [7:0]  home_owner;

	alloc_result_t pending_results[$];
	int            mismatches;
	int            cycles;
	bit            idle_gaps;
	// blocks currently allocated, so frees can target real blocks
	int            owned_blocks[$];

	function automatic int pool_limit();
		return (pool_total > NumBlocks) ? NumBlocks : int'(pool_total);
	endfunction

	function automatic int free_count();
		int lim;
		lim = pool_limit();
		return (lim > used_blocks) ? lim - used_blocks : 0;
	endfunction

	function automatic void push_result(status_t st, int b, bit lst);
		alloc_result_t r;
		r.status = st;
		r.blk = b[11:0];
		r.last = lst;
		r.used = used_blocks;
		pending_results.push_back(r);
	endfunction

	// lowest free block below the pool limit, -1 if none
	function automatic int grab_lowest();
		int lim;
		lim = pool_limit();
		for (int i = 0; i < lim; i++) begin
			if (!in_use_map[i]) begin
				in_use_map[i] = 1'b1;
				used_blocks = used_blocks + 13'd1;
				owned_blocks.push_back(i);
				return i;
			end
		end
		return -1;
	endfunction

	function automatic void predict_command(logic [2:0] c, logic [31:0] nbytes,
			logic [11:0] bnum, logic [7:0] owner);
		longint unsigned need;
		int b;
		case (c)
			CMD_ALLOC_BYTES: begin
				need = (longint'(nbytes) + (64'd1 << blk_size_log2) - 1) >> blk_size_log2;
				if (need == 0) push_result(ST_NOTHING, 0, 1'b1);
				else if (need > MaxRun) push_result(ST_TOOLARGE, 0, 1'b1);
				else if (need > free_count()) push_result(ST_NOSPACE, 0, 1'b1);
				else begin
					for (int k = 0; k < int'(need); k++) begin
						b = grab_lowest();
						push_result(ST_GIVEN, b, k + 1 == int'(need));
					end
				end
			end
			CMD_ALLOC_ONE: begin
				b = (free_count() == 0) ? -1 : grab_lowest();
				if (b < 0) push_result(ST_NOSPACE, 0, 1'b1);
				else push_result(ST_GIVEN, b, 1'b1);
			end
			CMD_FREE_CHK, CMD_FREE: begin
				if ((c == CMD_FREE_CHK && owner != home_owner) || !in_use_map[bnum]) begin
					push_result(ST_IGNORED, 0, 1'b1);
				end else begin
					in_use_map[bnum] = 1'b0;
					if (used_blocks > 0) used_blocks = used_blocks - 13'd1;
					foreach (owned_blocks[i])
						if (owned_blocks[i] == bnum) begin
							owned_blocks.delete(i);
							break;
						end
					push_result(ST_FREED, 0, 1'b1);
				end
			end
			CMD_REINIT: begin
				foreach (in_use_map[i]) in_use_map[i] = 1'b0;
				used_blocks = '0;
				owned_blocks.delete();
				push_result(ST_REINIT, 0, 1'b1);
			end
			// codes beyond reinit do nothing
			default: push_result(ST_NOTHING, 0, 1'b1);
		endcase
	endfunction

	// result checker: the receiver cannot stall, so every strobe is a transfer
	always @(posedge clk) begin
		alloc_result_t got, want;
		cycles <= cycles + 1;
		if (arst_n && result_valid) begin
			got = {status, block_number_out, last, used_count};
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result status=%0d blk=%0d last=%0d used=%0d",
						status, block_number_out, last, used_count);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch exp st=%0d blk=%0d last=%0d used=%0d",
							" got st=%0d blk=%0d last=%0d used=%0d"},
							want.status, want.blk, want.last, want.used,
							status, block_number_out, last, used_count);
				end
			end
		end
	end

	// watchdog: fails the run if the cycle counter runs past its limit
	always @(posedge clk) begin
		if (cycles > 400000) begin
			$display("Verification failed");
			$finish;
		end
	end

	// random sender gap
	task automatic maybe_gap();
		if (idle_gaps && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 8)) @(posedge clk);
	endtask

	// one command transfer: start held until accepted with busy low
	task automatic send_command(logic [2:0] c, logic [31:0] nbytes,
			logic [11:0] bnum, logic [7:0] owner);
		maybe_gap();
		start <= 1'b1;
		cmd <= c;
		request_bytes <= nbytes;
		block_number <= bnum;
		owner_server <= owner;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_command(c, nbytes, bnum, owner);
		start <= 1'b0;
		@(posedge clk);
	endtask

	// wait out every expected result, then the scan latency
	task automatic drain();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (250) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [12:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_BLOCK_SIZE_LOG2: blk_size_log2 = val[4:0];
			REG_TOTAL_BLOCKS:    pool_total = val;
			REG_LOCAL_SERVER:    home_owner = val[7:0];
			default: ;
		endcase
	endtask

	function automatic logic [11:0] pick_owned();
		if (owned_blocks.size() == 0) return 12'($urandom_range(0, 4095));
		return 12'(owned_blocks[$urandom_range(0, owned_blocks.size() - 1)]);
	endfunction

	// field extremes, every command and the named corner cases
	task automatic test_directed();
		send_command(CMD_ALLOC_BYTES, 32'd0, 12'd0, 8'd0);          // zero length
		send_command(CMD_ALLOC_BYTES, 32'd1, 12'd0, 8'd0);
		send_command(CMD_ALLOC_BYTES, 32'd4096 * 3 + 1, 12'd0, 8'd0);
		send_command(CMD_ALLOC_BYTES, 32'd4096 * 64, 12'd0, 8'd0);   // longest run
		send_command(CMD_ALLOC_BYTES, 32'd4096 * 64 + 1, 12'd0, 8'd0); // too long
		send_command(CMD_ALLOC_BYTES, 32'hFFFF_FFFF, 12'hFFF, 8'hFF);
		send_command(CMD_ALLOC_ONE, 32'd0, 12'd0, 8'd0);
		send_command(CMD_FREE, 32'd0, 12'd2, 8'd0);
		send_command(CMD_FREE, 32'd0, 12'd2, 8'd0);                  // double free
		send_command(CMD_FREE_CHK, 32'd0, 12'd3, 8'd7);              // foreign owner
		send_command(CMD_FREE_CHK, 32'd0, 12'd3, 8'd0);
		send_command(CMD_ALLOC_ONE, 32'd0, 12'd0, 8'd0);             // refills hole
		send_command(CMD_FREE, 32'd0, 12'hFFF, 8'd0);                // never used
		send_command(3'd5, 32'd0, 12'd0, 8'd0);                      // unknown codes
		send_command(3'd7, 32'hFFFF_FFFF, 12'hFFF, 8'hFF);
		send_command(CMD_REINIT, 32'd0, 12'd0, 8'd0);
		drain();
	endtask

	// tiny pool: short space, empty pool, then shrink under used blocks
	task automatic test_pool_limits();
		write_reg(REG_TOTAL_BLOCKS, 13'd3);
		write_reg(REG_BLOCK_SIZE_LOG2, 13'd6);
		write_reg(REG_LOCAL_SERVER, 13'd255);
		send_command(CMD_ALLOC_BYTES, 32'd200, 12'd0, 8'd0);         // needs 4 of 3
		send_command(CMD_ALLOC_BYTES, 32'd192, 12'd0, 8'd0);
		send_command(CMD_ALLOC_ONE, 32'd0, 12'd0, 8'd0);             // empty
		send_command(CMD_FREE_CHK, 32'd0, 12'd1, 8'd255);
		drain();
		write_reg(REG_TOTAL_BLOCKS, 13'd0);
		send_command(CMD_ALLOC_ONE, 32'd0, 12'd0, 8'd0);
		send_command(CMD_FREE, 32'd0, 12'd2, 8'd0);                  // shrunk pool
		drain();
		write_reg(REG_TOTAL_BLOCKS, 13'h1FFF);                       // beyond range
		write_reg(REG_BLOCK_SIZE_LOG2, 13'd31);
		send_command(CMD_ALLOC_BYTES, 32'hFFFF_FFFF, 12'd0, 8'd0);
		send_command(CMD_REINIT, 32'd0, 12'd0, 8'd0);
		drain();
	endtask

	// random mix over several register settings
	task automatic test_random(int count, int log2_sz, int total, int server);
		int sel;
		logic [31:0] nbytes;
		write_reg(REG_BLOCK_SIZE_LOG2, 13'(log2_sz));
		write_reg(REG_TOTAL_BLOCKS, 13'(total));
		write_reg(REG_LOCAL_SERVER, 13'(server));
		for (int n = 0; n < count; n++) begin
			sel = $urandom_range(0, 99);
			if (sel < 35) begin
				// mostly short runs, sometimes raw 32-bit noise
				if ($urandom_range(0, 9) == 0) nbytes = $urandom;
				else nbytes = $urandom_range(0, 12) << log2_sz;
				if ($urandom_range(0, 1)) nbytes = nbytes - $urandom_range(0, 3);
				send_command(CMD_ALLOC_BYTES, nbytes, 12'($urandom), 8'($urandom));
			end else if (sel < 60)
				send_command(CMD_ALLOC_ONE, $urandom, 12'($urandom), 8'($urandom));
			else if (sel < 90)
				send_command($urandom_range(0, 1) ? CMD_FREE : CMD_FREE_CHK, $urandom,
					$urandom_range(0, 3) == 0 ? 12'($urandom) : pick_owned(),
					$urandom_range(0, 2) == 0 ? 8'($urandom) : 8'(server));
			else if (sel < 95)
				send_command(CMD_REINIT, $urandom, 12'($urandom), 8'($urandom));
			else
				send_command(3'($urandom_range(5, 7)), $urandom, 12'($urandom),
					8'($urandom));
			// halfway through, the sender holds off until the allocator has fully drained
			if (n == count / 2) while (pending_results.size() != 0) @(posedge clk);
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		request_bytes = '0;
		block_number = '0;
		owner_server = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		mismatches = 0;
		cycles = 0;
		idle_gaps = 1'b1;
		foreach (in_use_map[i]) in_use_map[i] = 1'b0;
		used_blocks = '0;
		blk_size_log2 = 5'd12;
		pool_total = 13'd4096;
		home_owner = 8'd0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_pool_limits();
		test_random(25, 6, 40, 0);
		test_random(25, 20, 4096, 170);
		test_random(20, 9, 130, 85);
		// last part runs without idling
		idle_gaps = 1'b0;
		test_random(20, 12, 4096, 255);

		if (mismatches == 0 && pending_results.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
